>>> hdl/tsbrs_pkg.sv
// Shared types and constants for the two-stack binary radix sort sequencer.
// Used by the rank cell and the top level; depends on nothing.
package tsbrs_pkg;
	localparam int Depth = 512;
	localparam int ValueBits = 32;
	localparam int RankBits = $clog2(Depth);
	localparam int CountBits = $clog2(Depth + 1);

	typedef logic [1:0] action_t;
	localparam action_t ACT_LOAD = 2'd0;
	localparam action_t ACT_REQ = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

	typedef logic [1:0] op_t;
	localparam op_t OP_RA = 2'd0;
	localparam op_t OP_PB = 2'd1;
	localparam op_t OP_PA = 2'd2;
	localparam op_t OP_NONE = 2'd3;

	typedef struct packed {
		logic shift;
		logic load;
		logic [ValueBits-1:0] key;
		logic [RankBits-1:0] rank;
	} cell_ctl_t;
endpackage

>>> hdl/tsbrs_cell.sv
// One rank cell: holds one loaded key and its rank, and ranks a broadcast key.
// Depends on tsbrs_pkg.
module tsbrs_cell (
	input logic clk,
	input logic arst_n,
	input tsbrs_pkg::cell_ctl_t ctl,
	input logic here,
	input logic occupied,
	input logic [tsbrs_pkg::RankBits-1:0] next_rank,
	output logic le,
	output logic [tsbrs_pkg::RankBits-1:0] rank
);
	import tsbrs_pkg::*;

	logic [ValueBits-1:0] key_q;
	logic [RankBits-1:0] rank_q;

	assign le = occupied && (key_q <= ctl.key);
	assign rank = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			rank_q <= '0;
		end else if (ctl.shift) begin
			rank_q <= next_rank;
		end else if (ctl.load) begin
			if (here) begin
				key_q <= ctl.key;
				rank_q <= ctl.rank;
			end else if (occupied && !le) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end
endmodule

>>> hdl/two_stack_binary_radix_sort.sv
// Top level of the two-stack binary radix sort sequencer.
// Depends on tsbrs_pkg and tsbrs_cell.
//
// A command is transferred when start is high and busy is low. Action load
// places a signed value; action request returns one stack operation on op and
// last_op with result_valid high for one cycle; action clear restarts.
// A load keeps busy high in the count and write states: the cell row compares
// every stored key against the new key in parallel and a counter tree counts
// the stored keys that are not greater, then the new cell takes that rank and
// all greater cells move up one rank. A request keeps busy high in the read,
// execute, pop (pops only) and output states; its result is shown in the
// first cycle with busy low. The first request also shifts the ranks out of
// the row into a ring memory, one cell a cycle for each loaded value (up to Depth).
// A request after the end answers in the next cycle with busy staying low.
// Reset and clear empty the row and return to loading; no memory clearing pass
// is needed. The receiver cannot stall: each result is shown for one cycle.
module two_stack_binary_radix_sort (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic signed [31:0] value,
	output logic result_valid,
	output logic [1:0] op,
	output logic last_op
);
	import tsbrs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_COUNT, ST_WRITE, ST_COPY, ST_NORM, ST_RD, ST_EXEC, ST_POP, ST_OUT
	} state_t;

	state_t state_q;
	logic [ValueBits-1:0] key_q;
	logic [CountBits-1:0] a_count_q, b_count_q, pass_q, copy_q;
	logic [RankBits-1:0] a_head_q;
	logic [4:0] bit_pos_q, bit_tot_q;
	logic [1:0] phase_q;
	op_t op_q;
	logic valid_q, last_q;
	localparam logic [1:0] PH_LOAD = 2'd0, PH_SORT = 2'd1, PH_DONE = 2'd2;

	logic [Depth-1:0] le_v;
	logic [RankBits-1:0] rank_v [Depth+1];
	logic [CountBits-1:0] rank_sum_q;
	cell_ctl_t ctl;

	logic [RankBits-1:0] ring_mem [Depth];
	logic [RankBits-1:0] stk_mem [Depth];
	logic [RankBits-1:0] ring_rd_q, stk_rd_q;

	assign ctl.shift = (state_q == ST_COPY);
	assign ctl.key = key_q;
	assign ctl.load = (state_q == ST_WRITE);
	assign ctl.rank = rank_sum_q[RankBits-1:0];
	assign rank_v[Depth] = '0;

	genvar g;
	generate
		for (g = 0; g < Depth; g++) begin : g_cell
			tsbrs_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.here(a_count_q == CountBits'(g)),
				.occupied(CountBits'(g) < a_count_q),
				.next_rank(rank_v[g+1]),
				.le(le_v[g]), .rank(rank_v[g])
			);
		end
	endgenerate

	assign busy = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign op = op_q;
	assign last_op = last_q;

	logic [CountBits-1:0] total;
	logic [RankBits:0] tail;
	assign total = a_count_q + b_count_q;
	assign tail = {1'b0, a_head_q} + a_count_q[RankBits:0];
	logic [RankBits-1:0] tail_w;
	assign tail_w = (tail >= (RankBits+1)'(Depth)) ? RankBits'(tail - (RankBits+1)'(Depth))
		: tail[RankBits-1:0];
	logic [RankBits-1:0] head_inc, head_dec;
	assign head_inc = (a_head_q == RankBits'(Depth - 1)) ? '0 : a_head_q + 1'b1;
	assign head_dec = (a_head_q == '0) ? RankBits'(Depth - 1) : a_head_q - 1'b1;
	logic [CountBits-1:0] top;
	assign top = (a_count_q > 0) ? a_count_q - 1'b1 : '0;
	logic [4:0] nbits;
	always_comb begin
		nbits = '0;
		for (int i = 0; i < CountBits; i++) begin
			if (top[i]) nbits = 5'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		rank_sum_q <= CountBits'($countones(le_v));
		ring_rd_q <= ring_mem[a_head_q];
		stk_rd_q <= stk_mem[b_count_q[RankBits-1:0] - 1'b1];
		if (state_q == ST_COPY) begin
			ring_mem[copy_q[RankBits-1:0]] <= rank_v[0];
		end
		if (state_q == ST_EXEC && pass_q < total) begin
			if (ring_rd_q[bit_pos_q[3:0]]) begin
				ring_mem[tail_w] <= ring_rd_q;
			end else begin
				stk_mem[b_count_q[RankBits-1:0]] <= ring_rd_q;
			end
		end
		if (state_q == ST_POP) begin
			ring_mem[head_dec] <= stk_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_q <= '0;
			a_count_q <= '0; b_count_q <= '0; pass_q <= '0; copy_q <= '0;
			a_head_q <= '0; bit_pos_q <= '0; bit_tot_q <= '0;
			phase_q <= PH_LOAD; op_q <= OP_NONE; valid_q <= 1'b0; last_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q <= {value[ValueBits-1] ^ 1'b1, value[ValueBits-2:0]};
						case (action)
							ACT_LOAD: begin
								if (phase_q == PH_LOAD && a_count_q < CountBits'(Depth))
									state_q <= ST_COUNT;
							end
							ACT_REQ: begin
								if (phase_q == PH_LOAD) begin
									bit_tot_q <= nbits; bit_pos_q <= '0; pass_q <= '0;
									copy_q <= '0; phase_q <= PH_SORT;
									state_q <= (a_count_q == 0) ? ST_NORM : ST_COPY;
								end else if (phase_q == PH_SORT) begin
									state_q <= ST_RD;
								end else begin
									op_q <= OP_NONE; last_q <= 1'b1; valid_q <= 1'b1;
								end
							end
							ACT_CLEAR: begin
								a_count_q <= '0; b_count_q <= '0; a_head_q <= '0;
								bit_pos_q <= '0; bit_tot_q <= '0; pass_q <= '0;
								phase_q <= PH_LOAD;
							end
							default: ;
						endcase
					end
				end
				ST_COUNT: state_q <= ST_WRITE;
				ST_WRITE: begin
					a_count_q <= a_count_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_COPY: begin
					copy_q <= copy_q + 1'b1;
					if (copy_q + 1'b1 == a_count_q) state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (bit_pos_q >= bit_tot_q) begin
						phase_q <= PH_DONE;
						op_q <= OP_NONE; last_q <= 1'b1; valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (pass_q < total) begin
						pass_q <= pass_q + 1'b1;
						a_head_q <= head_inc;
						if (ring_rd_q[bit_pos_q[3:0]]) begin
							op_q <= OP_RA;
						end else begin
							op_q <= OP_PB;
							b_count_q <= b_count_q + 1'b1;
							a_count_q <= a_count_q - 1'b1;
						end
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					b_count_q <= b_count_q - 1'b1;
					a_head_q <= head_dec;
					a_count_q <= a_count_q + 1'b1;
					op_q <= OP_PA;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (pass_q < total || b_count_q != 0) begin
						last_q <= 1'b0; valid_q <= 1'b1; state_q <= ST_IDLE;
					end else if (bit_pos_q + 1'b1 >= bit_tot_q) begin
						phase_q <= PH_DONE; last_q <= 1'b1; valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						bit_pos_q <= bit_pos_q + 1'b1; pass_q <= '0;
						last_q <= 1'b0; valid_q <= 1'b1; state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) valid_q |-> state_q == ST_IDLE)
		else $error("result shown outside idle");
	assert property (@(posedge clk) disable iff (!arst_n) total <= CountBits'(Depth))
		else $error("stack total exceeds depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q && op_q != OP_NONE) |-> phase_q == PH_DONE)
		else $error("final operation without done phase");
endmodule
